// File: hdl/aesbc_pkg.sv
`timescale 1ns / 1ps
// aesbc_pkg: shared types, register codes and round functions of the aes block cipher core
// depends on nothing; used by the top level

package aesbc_pkg;

	localparam int BLOCK_BYTES = 16;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_KEY_SIZE   = 3'd0,
		REG_KEY_WORD_0 = 3'd1,
		REG_KEY_WORD_1 = 3'd2,
		REG_KEY_WORD_2 = 3'd3,
		REG_KEY_WORD_3 = 3'd4
	} cfg_idx_t;

	// operation codes
	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	// key size codes
	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_upper;
		logic [63:0] block_lower;
	} in_item_t;

	typedef struct packed {
		logic [63:0] text_upper;
		logic [63:0] text_lower;
	} out_item_t;

	typedef logic [7:0] sbox_tab_t [256];

	// multiply by x in the field
	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// general field multiply, only used while building the tables
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] aa;
		p  = 8'h00;
		aa = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p = p ^ aa;
			aa = xt(aa);
		end
		return p;
	endfunction

	// substitution table, forward or inverse, built at elaboration
	function automatic sbox_tab_t gen_sbox(input logic inverse);
		sbox_tab_t  fwd;
		sbox_tab_t  inv;
		logic [7:0] b;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			b = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gmul(8'(x), 8'(y)) == 8'h01)
					b = 8'(y);
			end
			s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
				^ 8'h63;
			fwd[x] = s;
		end
		for (int x = 0; x < 256; x++)
			inv[fwd[x]] = 8'(x);
		return inverse ? inv : fwd;
	endfunction

	localparam sbox_tab_t SBOX_FWD = gen_sbox(1'b0);
	localparam sbox_tab_t SBOX_INV = gen_sbox(1'b1);

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
	endfunction

	function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
		return s[127 - 8 * i -: 8];
	endfunction

	// sub bytes and shift rows in one go
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127 - 8 * (r + 4 * c) -: 8] = SBOX_FWD[byte_of(s, r + 4 * ((c + r) % 4))];
		return t;
	endfunction

	// inverse shift rows and inverse sub bytes
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = SBOX_INV[byte_of(s, r + 4 * c)];
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(s, 4 * c);
			a1 = byte_of(s, 4 * c + 1);
			a2 = byte_of(s, 4 * c + 2);
			a3 = byte_of(s, 4 * c + 3);
			t[127 - 32 * c -: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c - 8 -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			t[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			t[127 - 32 * c - 24 -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return t;
	endfunction

	// products by 9, 11, 13 and 14 from repeated doubling
	function automatic logic [7:0] m9(input logic [7:0] a);
		return xt(xt(xt(a))) ^ a;
	endfunction
	function automatic logic [7:0] m11(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(a) ^ a;
	endfunction
	function automatic logic [7:0] m13(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
	endfunction
	function automatic logic [7:0] m14(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
	endfunction

	function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(s, 4 * c);
			a1 = byte_of(s, 4 * c + 1);
			a2 = byte_of(s, 4 * c + 2);
			a3 = byte_of(s, 4 * c + 3);
			t[127 - 32 * c -: 8]      = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
			t[127 - 32 * c - 8 -: 8]  = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
			t[127 - 32 * c - 16 -: 8] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
			t[127 - 32 * c - 24 -: 8] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
		end
		return t;
	endfunction

	// one encryption round; the last one skips mix columns
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] a;
		a = sub_shift(s);
		if (!last)
			a = mix_cols(a);
		return a ^ rk;
	endfunction

	// one decryption round in inverse cipher order; the last one skips inverse mix columns
	function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] a;
		a = inv_shift_sub(s) ^ rk;
		if (!last)
			a = inv_mix_cols(a);
		return a;
	endfunction

endpackage

// File: hdl/aesbc_stream_if.sv
`timescale 1ns / 1ps
// aesbc_stream_if: valid/ready channel carrying one payload struct
// payload types come from aesbc_pkg

interface aesbc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/aesbc_ram.sv
`timescale 1ns / 1ps
// aesbc_ram: generic single write, single read ram with registered read data
// stand-alone, no package use

module aesbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// aes_block_cipher_core: iterative aes-128/192/256 encrypt and decrypt engine
// depends on aesbc_pkg, aesbc_stream_if and aesbc_ram
//
//   channel | direction | payload              | transaction when
//   blk     | sink      | cmd, block_upper/low | blk.valid && blk.ready
//   res     | source    | text_upper/lower     | res.valid && res.ready
//   cfg     | write     | cfg_index, cfg_wdata | cfg_we
//
// one round per cycle, round keys read from two 15-entry rams (upper and lower halves).
// the first item after a key register write first expands the schedule, one 32-bit word
// a cycle, 4 * (nr + 1) words in all. arst_n clears control and configuration state only.
// a finished result sits in the output register, so a new transaction is taken while
// it waits; the engine holds a finished block only when that register is still full.

module aes_block_cipher_core #(
	parameter int MAX_ROUNDS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	aesbc_stream_if.sink        blk,
	aesbc_stream_if.source      res
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int IW = $clog2(4 * (MAX_ROUNDS + 1));

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXPAND = 6'b000010,
		ST_LOAD   = 6'b000100,
		ST_ADD    = 6'b001000,
		ST_ROUND  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t        state_q;
	logic [1:0]    key_size_q;
	logic [63:0]   key_word_q [4];
	logic          sched_ready_q;
	logic [RW-1:0] nr_q;
	logic [RW-1:0] rnd_q;
	logic          fin_q;
	logic          dec_q;
	logic [127:0]  blk_q;
	logic [127:0]  st_q;
	logic          out_valid_q;
	aesbc_pkg::out_item_t out_q;

	// key expansion state
	logic [IW-1:0] widx_q;
	logic [2:0]    wmod_q;
	logic [7:0]    rcon_q;
	logic [31:0]   hist_q [8];

	logic [3:0]    nk;
	logic [RW-1:0] nr_exp;
	logic [31:0]   wnew;
	logic [31:0]   wback;
	logic [31:0]   tword;
	logic          exp_last;
	logic          we_u, we_l;
	logic [RW-1:0] raddr;
	logic [63:0]   rk_u, rk_l;
	logic [127:0]  rk;
	logic          fin_iss;
	logic          out_free;
	logic [RW-1:0] rnd_start;
	logic [RW-1:0] rnd_start_exp;

	// rounds from key size; size codes two and three count as 256 bits
	always_comb begin
		case (key_size_q)
			aesbc_pkg::KS_128: nk = 4'd4;
			aesbc_pkg::KS_192: nk = 4'd6;
			default:           nk = 4'd8;
		endcase
		if (32'(nk) + 32'd6 > MAX_ROUNDS)
			nr_exp = RW'(MAX_ROUNDS);
		else
			nr_exp = RW'(nk + 4'd6);
	end

	// next schedule word
	always_comb begin
		case (nk)
			4'd4:    wback = hist_q[3];
			4'd6:    wback = hist_q[5];
			default: wback = hist_q[7];
		endcase
		tword = hist_q[0];
		if (wmod_q == 3'd0)
			tword = aesbc_pkg::sub_word({hist_q[0][23:0], hist_q[0][31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && wmod_q == 3'd4)
			tword = aesbc_pkg::sub_word(hist_q[0]);
		if (widx_q < IW'(nk)) begin
			if (widx_q[0])
				wnew = key_word_q[widx_q[2:1]][31:0];
			else
				wnew = key_word_q[widx_q[2:1]][63:32];
		end else begin
			wnew = wback ^ tword;
		end
	end

	assign exp_last = (widx_q == IW'({nr_exp, 2'b11}));
	assign we_u     = (state_q == ST_EXPAND) && (widx_q[1:0] == 2'd1);
	assign we_l     = (state_q == ST_EXPAND) && (widx_q[1:0] == 2'd3);

	// round key rams, one entry per round
	aesbc_ram #(.WIDTH(64), .DEPTH(MAX_ROUNDS + 1)) u_ram_upper (
		.clk   (clk),
		.we    (we_u),
		.waddr (widx_q[IW-1:2]),
		.wdata ({hist_q[0], wnew}),
		.raddr (raddr),
		.rdata (rk_u)
	);

	aesbc_ram #(.WIDTH(64), .DEPTH(MAX_ROUNDS + 1)) u_ram_lower (
		.clk   (clk),
		.we    (we_l),
		.waddr (widx_q[IW-1:2]),
		.wdata ({hist_q[0], wnew}),
		.raddr (raddr),
		.rdata (rk_l)
	);

	assign rk        = {rk_u, rk_l};
	assign raddr     = rnd_q;
	assign fin_iss   = dec_q ? (rnd_q == '0) : (rnd_q == nr_q);
	assign out_free  = !out_valid_q || res.ready;
	assign rnd_start = blk.data.cmd ? nr_q : '0;
	assign rnd_start_exp = dec_q ? nr_exp : '0;

	assign blk.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q    <= '0;
			key_word_q[0] <= '0;
			key_word_q[1] <= '0;
			key_word_q[2] <= '0;
			key_word_q[3] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aesbc_pkg::REG_KEY_SIZE:   key_size_q    <= cfg_wdata[1:0];
				aesbc_pkg::REG_KEY_WORD_0: key_word_q[0] <= cfg_wdata;
				aesbc_pkg::REG_KEY_WORD_1: key_word_q[1] <= cfg_wdata;
				aesbc_pkg::REG_KEY_WORD_2: key_word_q[2] <= cfg_wdata;
				aesbc_pkg::REG_KEY_WORD_3: key_word_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sched_ready_q <= 1'b0;
			nr_q          <= '0;
			rnd_q         <= '0;
			fin_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			widx_q        <= '0;
			wmod_q        <= '0;
			rcon_q        <= 8'h01;
		end else begin
			if (res.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (blk.valid) begin
						if (sched_ready_q) begin
							rnd_q   <= rnd_start;
							state_q <= ST_LOAD;
						end else begin
							widx_q  <= '0;
							wmod_q  <= '0;
							rcon_q  <= 8'h01;
							state_q <= ST_EXPAND;
						end
					end
				end
				ST_EXPAND: begin
					widx_q <= widx_q + 1'b1;
					if (wmod_q == 3'(nk - 4'd1))
						wmod_q <= '0;
					else
						wmod_q <= wmod_q + 1'b1;
					if (wmod_q == 3'd0 && widx_q >= IW'(nk))
						rcon_q <= aesbc_pkg::xt(rcon_q);
					if (exp_last) begin
						sched_ready_q <= 1'b1;
						nr_q          <= nr_exp;
						rnd_q         <= rnd_start_exp;
						state_q       <= ST_LOAD;
					end
				end
				ST_LOAD, ST_ADD, ST_ROUND: begin
					if (state_q != ST_ROUND || !fin_q) begin
						fin_q <= fin_iss;
						if (!fin_iss)
							rnd_q <= dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
					end
					case (state_q)
						ST_LOAD: state_q <= ST_ADD;
						ST_ADD:  state_q <= ST_ROUND;
						default: if (fin_q) state_q <= ST_FINISH;
					endcase
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// any listed register write invalidates the schedule
			if (cfg_we && cfg_index <= aesbc_pkg::REG_KEY_WORD_3)
				sched_ready_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (blk.valid && blk.ready) begin
			dec_q <= (blk.data.cmd == aesbc_pkg::CMD_DECRYPT);
			blk_q <= {blk.data.block_upper, blk.data.block_lower};
		end
		if (state_q == ST_EXPAND) begin
			hist_q[0] <= wnew;
			for (int k = 1; k < 8; k++)
				hist_q[k] <= hist_q[k - 1];
		end
		if (state_q == ST_ADD)
			st_q <= blk_q ^ rk;
		else if (state_q == ST_ROUND)
			st_q <= dec_q ? aesbc_pkg::dec_round(st_q, rk, fin_q)
				: aesbc_pkg::enc_round(st_q, rk, fin_q);
		if (state_q == ST_FINISH && out_free)
			out_q <= st_q;
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_ready_skips_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(blk.valid && blk.ready && sched_ready_q && !cfg_we) |=> (state_q == ST_LOAD))
		else $error("expansion repeated with a valid schedule");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> res.valid)
		else $error("finished block not presented");
`endif

endmodule
